/* hdl/deadline_job_sequencer_macros.svh */
// Assertion macros shared by the deadline job sequencer checkers.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef DEADLINE_JOB_SEQUENCER_MACROS_SVH
`define DEADLINE_JOB_SEQUENCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DJS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DJS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/djs_pkg.sv */
// Shared types for the deadline job sequencer.
// Depends on nothing; imported by the cells and the top level.
package djs_pkg;

  localparam int DataW   = 16;
  localparam int TotalW  = 22;
  localparam int PlacedW = 7;

  // One stored job as it sits in, and moves along, the job chain.
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] deadline;
    logic [DataW-1:0] profit;
  } job_t;

  // Control broadcast to every job cell.
  typedef struct packed {
    logic load;
    logic pop;
  } job_ctrl_t;

  // Control broadcast to every slot cell.
  typedef struct packed {
    logic clr;
    logic inc;
  } slot_ctrl_t;

endpackage

/* hdl/deadline_job_sequencer.sv */
// Deadline job sequencer: jobs load at one request per cycle into a chain of cells sorted
// by profit. After the request that closes a batch of n jobs, scheduling pops one job per
// cycle, a drain state evaluates the last job, and the result is registered in the finish
// state, or later while an earlier result is stalled; no request is taken meanwhile.
// Synchronous active-low reset empties the chain and clears counters and flags; job and
// result payload registers are not reset.
module deadline_job_sequencer import djs_pkg::*; #(
  parameter int MAX_JOBS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DataW-1:0]   in_deadline,
  input  logic [DataW-1:0]   in_profit,
  input  logic               in_last_job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TotalW-1:0]  out_total_profit,
  output logic [PlacedW-1:0] out_jobs_scheduled,
  output logic               out_overflow
);

  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_JOBS);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_POP   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic               ovf_r, ovf_nxt;
  logic               ev_valid_r, ev_valid_nxt;
  logic [CW-1:0]      ev_e_r, ev_e_nxt;
  logic [DataW-1:0]   ev_prof_r;
  logic [TotalW-1:0]  total_r, total_nxt;
  logic [PlacedW-1:0] placed_r, placed_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TotalW-1:0]  out_total_r;
  logic [PlacedW-1:0] out_placed_r;
  logic               out_ovf_r;

  logic               in_acc;
  logic               full;
  logic               close;
  logic               fin_write;
  logic               accept;
  logic [TotalW:0]    sum;

  job_t                cell_q [MAX_JOBS];
  logic [MAX_JOBS-1:0] ins_vec;
  logic [MAX_JOBS-1:0] ok_vec;
  job_t                new_job;
  job_ctrl_t           jctrl;
  slot_ctrl_t          sctrl;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign full      = (count_r == MaxCnt);
  assign close     = in_acc && in_last_job;
  assign fin_write = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  assign new_job   = '{valid: 1'b1, deadline: in_deadline, profit: in_profit};
  assign jctrl     = '{load: in_acc && !full, pop: (state_r == ST_POP)};

  // Row of job cells, sorted by profit with the best at cell zero.
  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_job
    job_t prev_j, next_j;
    logic prev_i;
    if (i == 0) begin : g_head
      assign prev_j = '0;
      assign prev_i = 1'b0;
    end else begin : g_mid
      assign prev_j = cell_q[i-1];
      assign prev_i = ins_vec[i-1];
    end
    if (i == MAX_JOBS - 1) begin : g_tail
      assign next_j = '0;
    end else begin : g_body
      assign next_j = cell_q[i+1];
    end
    djs_job_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (jctrl),
      .new_job  (new_job),
      .prev_job (prev_j),
      .prev_ins (prev_i),
      .next_job (next_j),
      .job      (cell_q[i]),
      .ins      (ins_vec[i])
    );
  end

  // A job fits when every bound at or above its effective deadline has room.
  assign accept = ev_valid_r && (ev_e_r != '0) && (&ok_vec);
  assign sctrl  = '{clr: (state_r == ST_LOAD), inc: accept};

  for (genvar t = 0; t < MAX_JOBS; t++) begin : g_slot
    djs_slot_cell #(.CW(CW), .IDX(t + 1)) u_slot (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (sctrl),
      .eff   (ev_e_r),
      .ok    (ok_vec[t])
    );
  end

  // Effective deadline of the job leaving the head: min(deadline, n).
  always_comb begin
    if (cell_q[0].deadline > DataW'(n_r)) begin
      ev_e_nxt = n_r;
    end else begin
      ev_e_nxt = cell_q[0].deadline[CW-1:0];
    end
  end
  assign ev_valid_nxt = (state_r == ST_POP);

  // Saturating accumulation of profit and placed count.
  assign sum = {1'b0, total_r} + (TotalW + 1)'(ev_prof_r);
  always_comb begin
    total_nxt  = total_r;
    placed_nxt = placed_r;
    if (close) begin
      total_nxt  = '0;
      placed_nxt = '0;
    end else if (accept) begin
      total_nxt = sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0];
      if (placed_r != {PlacedW{1'b1}}) begin
        placed_nxt = placed_r + PlacedW'(1);
      end
    end
  end

  // Sequencer: load, pop one job per cycle, drain the last evaluation, report.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    rem_nxt       = rem_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CW'(1);
          end
          if (in_last_job) begin
            n_nxt     = full ? count_r : count_r + CW'(1);
            rem_nxt   = n_nxt;
            count_nxt = '0;
            state_nxt = ST_POP;
          end
        end
      end
      ST_POP: begin
        rem_nxt = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_write) begin
          out_valid_nxt = 1'b1;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      n_r         <= '0;
      rem_r       <= '0;
      ovf_r       <= 1'b0;
      ev_valid_r  <= 1'b0;
      total_r     <= '0;
      placed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      rem_r       <= rem_nxt;
      ovf_r       <= ovf_nxt;
      ev_valid_r  <= ev_valid_nxt;
      total_r     <= total_nxt;
      placed_r    <= placed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: evaluation stage and result.
  always_ff @(posedge clk) begin
    ev_e_r    <= ev_e_nxt;
    ev_prof_r <= cell_q[0].profit;
    if (fin_write) begin
      out_total_r  <= total_r;
      out_placed_r <= placed_r;
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_total_profit   = out_total_r;
  assign out_jobs_scheduled = out_placed_r;
  assign out_overflow       = out_ovf_r;

endmodule

/* hdl/djs_job_cell.sv */
// One cell of the profit-sorted job chain.
// Depends on djs_pkg; instantiated in a row by deadline_job_sequencer.
module djs_job_cell import djs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_ctrl_t ctrl,
  input  job_t      new_job,
  input  job_t      prev_job,
  input  logic      prev_ins,
  input  job_t      next_job,
  output job_t      job,
  output logic      ins
);

  logic             valid_r, valid_nxt;
  logic [DataW-1:0] dl_r, dl_nxt;
  logic [DataW-1:0] pf_r, pf_nxt;

  assign job = '{valid: valid_r, deadline: dl_r, profit: pf_r};

  // The new request goes in front of this cell when it has strictly more
  // profit, so that equal profits stay in arrival order.
  assign ins = ctrl.load && (!valid_r || (new_job.profit > pf_r));

  // Pop shifts towards the head; insertion shifts towards the tail.
  always_comb begin
    valid_nxt = valid_r;
    dl_nxt    = dl_r;
    pf_nxt    = pf_r;
    if (ctrl.pop) begin
      valid_nxt = next_job.valid;
      dl_nxt    = next_job.deadline;
      pf_nxt    = next_job.profit;
    end else if (ins) begin
      if (prev_ins) begin
        valid_nxt = prev_job.valid;
        dl_nxt    = prev_job.deadline;
        pf_nxt    = prev_job.profit;
      end else begin
        valid_nxt = 1'b1;
        dl_nxt    = new_job.deadline;
        pf_nxt    = new_job.profit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r <= dl_nxt;
    pf_r <= pf_nxt;
  end

endmodule

/* hdl/djs_slot_cell.sv */
// One cell of the slot occupancy row: counts the jobs placed with an
// effective deadline at or below its own bound. Depends on djs_pkg.
module djs_slot_cell import djs_pkg::*; #(
  parameter int CW  = 7,
  parameter int IDX = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  slot_ctrl_t    ctrl,
  input  logic [CW-1:0] eff,
  output logic          ok
);

  localparam logic [CW-1:0] Bound = CW'(IDX);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          covered;

  // This bound is affected only by jobs whose effective deadline is at or
  // below it; such a job fits here while fewer than IDX jobs are counted.
  assign covered = (eff <= Bound);
  assign ok      = !covered || (cnt_r < Bound);

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.clr) begin
      cnt_nxt = '0;
    end else if (ctrl.inc && covered) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hdl/djs_checker.sv */
// Port-level checks for the deadline job sequencer, bound to the top level.
// Depends on djs_pkg and deadline_job_sequencer_macros.svh.
`include "deadline_job_sequencer_macros.svh"

module djs_checker import djs_pkg::*; #(
  parameter int MAX_JOBS = 64
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [DataW-1:0]   in_deadline,
  input logic [DataW-1:0]   in_profit,
  input logic               in_last_job,
  input logic               out_valid,
  input logic               out_ready,
  input logic [TotalW-1:0]  out_total_profit,
  input logic [PlacedW-1:0] out_jobs_scheduled,
  input logic               out_overflow
);

  logic                      in_acc;
  logic                      in_stall;
  logic                      out_stall;
  logic                      no_jobs;
  logic [2*DataW:0]          in_word;
  logic [TotalW+PlacedW:0]   out_word;

  assign in_acc    = in_valid && in_ready;
  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;
  assign no_jobs   = out_valid && (out_jobs_scheduled == '0);
  assign in_word   = {in_deadline, in_profit, in_last_job};
  assign out_word  = {out_total_profit, out_jobs_scheduled, out_overflow};

  // A stalled result stays offered and unchanged.
  `DJS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "result lost")

  // A waiting request stays offered and unchanged.
  `DJS_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable(in_word), "request changed")

  // Closing a batch always starts scheduling, so no request is taken next.
  `DJS_ASSERT_NEXT(a_close_busy, in_acc && in_last_job, !in_ready, "request in scheduling")

  // No scheduled job means no profit.
  `DJS_ASSERT_NOW(a_zero_jobs, no_jobs, out_total_profit == '0, "profit without jobs")

  // Never more jobs placed than the store can hold.
  `DJS_ASSERT_NOW(a_jobs_bound, out_valid, int'(out_jobs_scheduled) <= MAX_JOBS, "too many jobs")

endmodule

bind deadline_job_sequencer djs_checker #(.MAX_JOBS(MAX_JOBS)) u_djs_checker (.*);
